>>> hdl/wzht_pkg.sv
// Shared types and constants for the window z-order hit test block.
package wzht_pkg;

    // Width of every coordinate field on the input channel
    localparam int FIELD_W = 12;
    // Width of the window id on the result channel
    localparam int ID_W    = 5;

    // Input item opcodes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CLICK = 1'b1;

    // Input item
    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] left;
        logic [FIELD_W-1:0] bottom;
        logic [FIELD_W-1:0] right;
        logic [FIELD_W-1:0] top;
        logic [FIELD_W-1:0] click_x;
        logic [FIELD_W-1:0] click_y;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] window_id;
    } out_item_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT,
        ST_UPDATE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;    // write the incoming rectangle on top of the stack
        logic capture;    // latch click point, clear best match
        logic ptr_clr;    // rewind the memory walk pointer
        logic rd_issue;   // read the entry at the walk pointer
        logic upd_mode;   // returning reads are rewritten with new ranks
        logic out_load;   // load the result register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic ptr_end;    // walk pointer reached the window count
        logic rd_vld;     // read data is in flight this cycle
        logic best_vld;   // the scan found a containing window
        logic out_free;   // result register can take a new item
    } dp_status_t;

endpackage

>>> hdl/wzht_ctrl.sv
// Controller state machine: sequences load, scan, result and rank update.
module wzht_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_command,
    output logic                  s_ready,
    input  wzht_pkg::dp_status_t  status,
    output wzht_pkg::ctrl_cmd_t   cmd
);

    wzht_pkg::state_t state_reg;
    wzht_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wzht_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            wzht_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == wzht_pkg::CMD_LOAD) begin
                        cmd.load_wr = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        cmd.ptr_clr = 1'b1;
                        state_next  = wzht_pkg::ST_SCAN;
                    end
                end
            end
            wzht_pkg::ST_SCAN: begin
                // walk every stored window, keep the highest ranked hit
                cmd.rd_issue = !status.ptr_end;
                if (status.ptr_end && !status.rd_vld) begin
                    state_next = wzht_pkg::ST_RESULT;
                end
            end
            wzht_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.ptr_clr  = 1'b1;
                    state_next   = status.best_vld ? wzht_pkg::ST_UPDATE
                                                   : wzht_pkg::ST_IDLE;
                end
            end
            wzht_pkg::ST_UPDATE: begin
                // second walk: read, re-rank, write back
                cmd.upd_mode = 1'b1;
                cmd.rd_issue = !status.ptr_end;
                if (status.ptr_end && !status.rd_vld) begin
                    state_next = wzht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wzht_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/wzht_datapath.sv
// Datapath: rectangle/rank memory, walk pointer, hit compare and result register.
module wzht_datapath #(
    parameter int MAX_WINDOWS = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wzht_pkg::in_item_t    s_data,
    input  wzht_pkg::ctrl_cmd_t   cmd,
    output wzht_pkg::dp_status_t  status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wzht_pkg::out_item_t   m_data
);

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int CW    = (COORD_BITS < wzht_pkg::FIELD_W) ? COORD_BITS
                                                            : wzht_pkg::FIELD_W;
    localparam int ENT_W = 4 * CW + IDX_W;
    localparam int IDF_W = IDX_W + 1;

    // Entry layout: left, bottom, right, top, z rank (0 = bottom of stack)
    logic [ENT_W-1:0] store_mem [MAX_WINDOWS];

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic [ENT_W-1:0] rd_data_reg;
    logic [CW-1:0]    click_x_reg;
    logic [CW-1:0]    click_y_reg;
    logic             best_vld_reg;
    logic             best_vld_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;
    logic [IDX_W-1:0] best_rank_reg;
    logic [IDX_W-1:0] best_rank_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    wzht_pkg::out_item_t m_data_reg;
    wzht_pkg::out_item_t m_data_next;

    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [CW-1:0]    rd_left;
    logic [CW-1:0]    rd_bottom;
    logic [CW-1:0]    rd_right;
    logic [CW-1:0]    rd_top;
    logic [IDX_W-1:0] rd_rank;
    logic [IDX_W-1:0] top_rank;
    logic [IDX_W-1:0] new_rank;
    logic             inside_rect;
    logic [IDF_W-1:0] id_full;

    assign full = (cnt_reg == CNT_W'(MAX_WINDOWS));

    // Fields of the entry coming back from memory
    assign rd_left   = rd_data_reg[ENT_W-1      -: CW];
    assign rd_bottom = rd_data_reg[ENT_W-1-CW   -: CW];
    assign rd_right  = rd_data_reg[ENT_W-1-2*CW -: CW];
    assign rd_top    = rd_data_reg[ENT_W-1-3*CW -: CW];
    assign rd_rank   = rd_data_reg[IDX_W-1:0];

    // Inclusive containment test of the click point
    assign inside_rect = (click_x_reg >= rd_left)   && (click_x_reg <= rd_right) &&
                         (click_y_reg >= rd_bottom) && (click_y_reg <= rd_top);

    // Re-rank: clicked window goes to the top, windows above it drop one
    assign top_rank = IDX_W'(cnt_reg - CNT_W'(1));
    always_comb begin
        if (rd_addr_reg == best_idx_reg) begin
            new_rank = top_rank;
        end else if (rd_rank > best_rank_reg) begin
            new_rank = rd_rank - IDX_W'(1);
        end else begin
            new_rank = rd_rank;
        end
    end

    // Memory write port: load on top of stack, or rank write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = {rd_data_reg[ENT_W-1:IDX_W], new_rank};
        if (cmd.load_wr) begin
            wr_en   = !full;
            wr_addr = cnt_reg[IDX_W-1:0];
            wr_data = {s_data.left[CW-1:0], s_data.bottom[CW-1:0],
                       s_data.right[CW-1:0], s_data.top[CW-1:0],
                       cnt_reg[IDX_W-1:0]};
        end else if (cmd.upd_mode && rd_vld_reg) begin
            wr_en = 1'b1;
        end
    end

    // Memory array with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= store_mem[ptr_reg[IDX_W-1:0]];
            rd_addr_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.capture) begin
            click_x_reg <= s_data.click_x[CW-1:0];
            click_y_reg <= s_data.click_y[CW-1:0];
        end
    end

    // Count, walk pointer and best-match tracking
    always_comb begin
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_rank_next = best_rank_reg;
        if (cmd.load_wr && !full) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.ptr_clr) begin
            ptr_next = '0;
        end else if (cmd.rd_issue) begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
        if (cmd.capture) begin
            best_vld_next = 1'b0;
        end else if (rd_vld_reg && !cmd.upd_mode && inside_rect &&
                     (!best_vld_reg || rd_rank > best_rank_reg)) begin
            best_vld_next  = 1'b1;
            best_idx_next  = rd_addr_reg;
            best_rank_next = rd_rank;
        end
    end

    // Result register
    assign id_full = IDF_W'(best_idx_reg) + IDF_W'(1);
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (cmd.out_load) begin
            m_valid_next          = 1'b1;
            m_data_next.hit       = best_vld_reg;
            m_data_next.window_id = best_vld_reg ? wzht_pkg::ID_W'(id_full) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            rd_vld_reg   <= cmd.rd_issue;
            best_vld_reg <= best_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_idx_reg  <= best_idx_next;
        best_rank_reg <= best_rank_next;
        m_data_reg    <= m_data_next;
    end

    assign status.ptr_end  = (ptr_reg == cnt_reg);
    assign status.rd_vld   = rd_vld_reg;
    assign status.best_vld = best_vld_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/window_zorder_hit_test.sv
// Top level of the window z-order hit test with click-to-front.
//
//  Channel   Ports                        Carries
//  input     s_valid s_ready s_data       load rectangle or click point
//  result    m_valid m_ready m_data       hit flag and window id, one per click
//
//  A load is written while the block stays idle. A click is accepted, then the
//  stored windows are scanned, the result is posted, and on a hit the memory is
//  walked again to rewrite the z ranks; the scan and the rewrite are both set by
//  the single read port of the window memory.
//  Reset (aresetn low, synchronous) empties the stack; memory is not cleared.
//  A held result item stalls the next click at its result post, and with it the
//  input; loads and the rank rewrite of a click already posted go on meanwhile.
module window_zorder_hit_test #(
    parameter int MAX_WINDOWS = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wzht_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wzht_pkg::out_item_t  m_data
);

    wzht_pkg::ctrl_cmd_t  cmd;
    wzht_pkg::dp_status_t status;

    // Sequencer
    wzht_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage, compare and result register
    wzht_datapath #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> hdl/wzht_checker.sv
// Port-level checker for the window z-order hit test, bound to the top level.
module wzht_checker #(
    parameter int MAX_WINDOWS = 16
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input wzht_pkg::in_item_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input wzht_pkg::out_item_t  m_data
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Reset empties the result register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A miss reports id zero
    a_miss_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.window_id == '0)
        else $error("miss with nonzero window id");

    // A hit reports an id that was handed out
    a_hit_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |->
            (MAX_WINDOWS > 31) ||
            (m_data.window_id != '0 && m_data.window_id <= MAX_WINDOWS))
        else $error("hit with impossible window id");

    // A click occupies the block: no item is taken in the next cycle
    a_click_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == wzht_pkg::CMD_CLICK |=> !s_ready)
        else $error("item accepted right after a click");

endmodule

bind window_zorder_hit_test wzht_checker #(
    .MAX_WINDOWS (MAX_WINDOWS)
) u_wzht_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> verif/wzht_checker.sv
// Scoreboard for the window z-order hit test: tracks the stack and scores every result item.
module wzht_scoreboard #(
    parameter int MAX_WINDOWS = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  wzht_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  wzht_pkg::out_item_t m_data,
    output int                  fail_count,
    output int                  pending
);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t left;
        coord_t bottom;
        coord_t right;
        coord_t top;
    } rect_t;

    // Shadow copy of the window stack
    rect_t               win_rect [MAX_WINDOWS];
    int                  z_slot   [MAX_WINDOWS];  // store index per stack position, 0 = top
    int                  win_count;
    wzht_pkg::out_item_t expected_hits[$];

    // New window goes on top; ignored once the stack is full
    function automatic void push_window(input wzht_pkg::in_item_t it);
        if (win_count >= MAX_WINDOWS)
            return;
        win_rect[win_count] = '{left:   coord_t'(it.left),
                                bottom: coord_t'(it.bottom),
                                right:  coord_t'(it.right),
                                top:    coord_t'(it.top)};
        for (int k = win_count; k > 0; k--)
            z_slot[k] = z_slot[k-1];
        z_slot[0] = win_count;
        win_count++;
    endfunction

    // Topmost containing window wins and moves to the front
    function automatic wzht_pkg::out_item_t resolve_click(input coord_t x, input coord_t y);
        wzht_pkg::out_item_t res;
        int                  idx;
        res = '0;
        for (int k = 0; k < win_count; k++) begin
            idx = z_slot[k];
            if (x >= win_rect[idx].left && x <= win_rect[idx].right &&
                y >= win_rect[idx].bottom && y <= win_rect[idx].top) begin
                for (int m = k; m > 0; m--)
                    z_slot[m] = z_slot[m-1];
                z_slot[0]     = idx;
                res.hit       = 1'b1;
                res.window_id = wzht_pkg::ID_W'(idx + 1);
                return res;
            end
        end
        return res;
    endfunction

    // Score results first, then fold in the accepted item
    always @(posedge aclk) begin
        wzht_pkg::out_item_t want;
        wzht_pkg::out_item_t click_res;
        if (!aresetn) begin
            win_count = 0;
            expected_hits.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, got hit=%0b id=%0d",
                             $time, m_data.hit, m_data.window_id);
                    fail_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (m_data.hit !== want.hit)
                        $display("%0t: hit mismatch: expected %0b, got %0b",
                                 $time, want.hit, m_data.hit);
                    if (m_data.window_id !== want.window_id)
                        $display("%0t: window_id mismatch: expected %0d, got %0d",
                                 $time, want.window_id, m_data.window_id);
                    if (m_data !== want)
                        fail_count++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.command == wzht_pkg::CMD_CLICK) begin
                    click_res = resolve_click(coord_t'(s_data.click_x),
                                              coord_t'(s_data.click_y));
                    expected_hits.insert(expected_hits.size(), click_res);
                end else begin
                    push_window(s_data);
                end
            end
            pending = expected_hits.size();
        end
    end

endmodule

>>> verif/tb_window_zorder_hit_test.sv
// Testbench top for the window z-order hit test: stimulus, receiver stalls and verdict.
module tb_window_zorder_hit_test;

    localparam int MAX_WINDOWS     = 16;
    localparam int COORD_BITS      = 12;
    localparam int CMAX            = (1 << COORD_BITS) - 1;
    localparam int ITEM_TARGET     = 1850;
    localparam int IDLE_LIMIT      = 4000;   // well above the long hold-off
    localparam int HOLD_OFF_AT     = 8000;   // cycle at which the long hold-off starts
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 50;     // covers a full-stack scan and rank rewrite

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    wzht_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    wzht_pkg::out_item_t m_data;
    int                  fail_count;
    int                  pending;

    // Stimulus bookkeeping: what has been loaded, for aiming clicks
    wzht_pkg::in_item_t  stored_win[MAX_WINDOWS];
    int                  loaded_n      = 0;
    int                  items_counted = 0;
    int                  burst_left    = 0;
    int                  idle_cycles   = 0;

    always #5 aclk = ~aclk;

    window_zorder_hit_test #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_BITS  (COORD_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    wzht_scoreboard #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_BITS  (COORD_BITS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one item in bursts; called and returns at a falling edge
    task automatic offer_item(input wzht_pkg::in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
        @(negedge aclk);
        burst_left--;
        items_counted++;
        if (it.command == wzht_pkg::CMD_LOAD && loaded_n < MAX_WINDOWS) begin
            stored_win[loaded_n] = it;
            loaded_n++;
        end
    endtask

    // Load item; click fields carry junk
    task automatic load_rect(input int l, input int b, input int r, input int t);
        wzht_pkg::in_item_t it;
        it.command = wzht_pkg::CMD_LOAD;
        it.left    = wzht_pkg::FIELD_W'(l);
        it.bottom  = wzht_pkg::FIELD_W'(b);
        it.right   = wzht_pkg::FIELD_W'(r);
        it.top     = wzht_pkg::FIELD_W'(t);
        it.click_x = wzht_pkg::FIELD_W'($urandom_range(0, CMAX));
        it.click_y = wzht_pkg::FIELD_W'($urandom_range(0, CMAX));
        offer_item(it);
    endtask

    // Click item; rectangle fields carry junk
    task automatic click_at(input int x, input int y);
        wzht_pkg::in_item_t it;
        it.command = wzht_pkg::CMD_CLICK;
        it.left    = wzht_pkg::FIELD_W'($urandom_range(0, CMAX));
        it.bottom  = wzht_pkg::FIELD_W'($urandom_range(0, CMAX));
        it.right   = wzht_pkg::FIELD_W'($urandom_range(0, CMAX));
        it.top     = wzht_pkg::FIELD_W'($urandom_range(0, CMAX));
        it.click_x = wzht_pkg::FIELD_W'(x);
        it.click_y = wzht_pkg::FIELD_W'(y);
        offer_item(it);
    endtask

    // Mostly modest rectangles so they overlap without covering everything
    task automatic load_random_rect();
        int l, b, w, h;
        l = $urandom_range(0, CMAX);
        b = $urandom_range(0, CMAX);
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CMAX) : $urandom_range(0, 800);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CMAX) : $urandom_range(0, 800);
        load_rect(l, b, (l + w > CMAX) ? CMAX : l + w, (b + h > CMAX) ? CMAX : b + h);
    endtask

    // Click inside a stored non-empty window, often on its edges; a random click if none is found
    task automatic aimed_click();
        wzht_pkg::in_item_t w;
        int                 x, y;
        bit                 found;
        found = 1'b0;
        for (int tries = 0; tries < 8 && !found; tries++) begin
            w = stored_win[$urandom_range(0, loaded_n - 1)];
            found = (w.left <= w.right) && (w.bottom <= w.top);
        end
        if (!found) begin
            click_at($urandom_range(0, CMAX), $urandom_range(0, CMAX));
        end else begin
            case ($urandom_range(0, 5))
                0:       x = int'(w.left);
                1:       x = int'(w.right);
                default: x = $urandom_range(w.left, w.right);
            endcase
            case ($urandom_range(0, 5))
                0:       y = int'(w.bottom);
                1:       y = int'(w.top);
                default: y = $urandom_range(w.bottom, w.top);
            endcase
            click_at(x, y);
        end
    endtask

    // Receiver: changing stall patterns plus one long hold-off
    initial begin
        rx_mode_t mode;
        int       cyc, mode_left, hold_left;
        bit       hold_done;
        mode      = RX_OPEN;
        cyc       = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && cyc >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                m_ready  <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int sel;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty stack, extreme corners, empty rectangles, inclusive edges
        click_at(2048, 2048);                   // no windows yet: miss
        load_rect(0, 0, 0, 0);                  // id 1: origin point
        load_rect(CMAX, CMAX, CMAX, CMAX);      // id 2: far corner point
        click_at(0, 0);
        click_at(CMAX, CMAX);
        click_at(0, 1);                         // just off the origin: miss
        load_rect(3000, 0, 2999, CMAX);         // id 3: empty in x
        load_rect(0, 10, CMAX, 9);              // id 4: empty in y
        click_at(2999, 9);                      // only empty windows there: miss
        load_rect(100, 300, 200, 400);          // id 5
        load_rect(150, 350, 250, 450);          // id 6 overlaps id 5
        click_at(175, 375);                     // topmost of the two
        click_at(100, 300);                     // lower-left corner of id 5
        click_at(175, 375);                     // id 5 now in front
        click_at(250, 450);                     // upper-right corner of id 6
        click_at(251, 450);                     // one past the edge
        click_at(200, 300);
        load_rect(0, 0, CMAX, 0);               // id 7: bottom row
        click_at(CMAX, 0);
        click_at(0, 0);                         // id 7 covers id 1

        // Fill the stack, then loads against a full stack
        while (loaded_n < MAX_WINDOWS)
            load_random_rect();
        load_random_rect();
        load_random_rect();

        // Random: mostly aimed clicks, some stray clicks and ignored loads
        while (items_counted < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                load_rect($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                          $urandom_range(0, CMAX), $urandom_range(0, CMAX));
            else if (sel < 28)
                click_at($urandom_range(0, CMAX), $urandom_range(0, CMAX));
            else
                aimed_click();
        end
        s_valid <= 1'b0;

        while (pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/wzht_pkg.sv
hdl/wzht_ctrl.sv
hdl/wzht_datapath.sv
hdl/window_zorder_hit_test.sv
hdl/wzht_checker.sv
verif/wzht_checker.sv
verif/tb_window_zorder_hit_test.sv
